FILE: src/assert_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CHK_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: src/crcfr_pkg.sv
`timescale 1ns / 1ps
package crcfr_pkg;

  localparam int FRAME_LEN    = 256;
  localparam int ADDR_W       = $clog2(FRAME_LEN);
  localparam int POS_W        = ADDR_W + 1;
  localparam int MAX_DATA_DEF = 248;
  localparam int UIO_LEN_DEF  = 8;
  localparam int BEAT_BYTES   = 8;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);

  localparam logic [7:0]  SYNC_START = 8'h55;
  localparam logic [7:0]  SYNC_STOP  = 8'hAA;
  localparam logic [15:0] CRC_INIT   = 16'hEF4A;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  TYPE_METRIC = 8'd1;
  localparam logic [7:0]  TYPE_UIO    = 8'd2;

  // Header, data, CRC and stop byte positions inside the window
  localparam logic [POS_W-1:0] POS_SYNC   = 9'd0;
  localparam logic [POS_W-1:0] POS_SLOT   = 9'd1;
  localparam logic [POS_W-1:0] POS_TYPE   = 9'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO = 9'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI = 9'd4;
  localparam logic [POS_W-1:0] POS_DATA   = 9'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO = 9'd253;
  localparam logic [POS_W-1:0] POS_CRC_HI = 9'd254;
  localparam logic [POS_W-1:0] POS_STOP   = 9'd255;
  localparam logic [POS_W-1:0] POS_END    = 9'd256;

  // Register indexes
  localparam logic CFG_SIGNAL_EN = 1'b0;
  localparam logic CFG_UIO_EN    = 1'b1;

  typedef struct packed {
    logic        sig_en;
    logic        uio_en;
  } cfg_t;

  typedef struct packed {
    logic        full;
    logic        empty;
  } queue_stat_t;

  typedef struct packed {
    logic [7:0]  slot_number;
    logic [1:0]  frame_type;
    logic [7:0]  frame_length;
    logic [63:0] data_word;
    logic [3:0]  bytes_valid;
    logic [4:0]  beat_index;
    logic        last_beat;
  } beat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR0, S_HDR1, S_EVAL, S_CRC, S_DEC, S_DATA, S_PUSH
  } front_state_t;

  // One byte of CRC-16, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (r[15]) r = {r[14:0], 1'b0} ^ CRC_POLY;
      else       r = {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: src/crcfr_if.sv
`timescale 1ns / 1ps
interface crcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfr_beat_if;
  logic        valid;
  logic        ready;
  logic [7:0]  slot_number;
  logic [1:0]  frame_type;
  logic [7:0]  frame_length;
  logic [63:0] data_word;
  logic [3:0]  bytes_valid;
  logic [4:0]  beat_index;
  logic        last_beat;
  modport source (output valid, output slot_number, output frame_type,
                  output frame_length, output data_word, output bytes_valid,
                  output beat_index, output last_beat, input ready);
  modport sink (input valid, input slot_number, input frame_type,
                input frame_length, input data_word, input bytes_valid,
                input beat_index, input last_beat, output ready);
endinterface

FILE: src/crcfr_front.sv
`timescale 1ns / 1ps
module crcfr_front #(
  parameter int MAX_DATA = crcfr_pkg::MAX_DATA_DEF,
  parameter int UIO_LEN  = crcfr_pkg::UIO_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  crcfr_byte_if.sink          rx,
  input  crcfr_pkg::cfg_t     cfg,
  input  crcfr_pkg::queue_stat_t q_stat,
  output logic                q_push,
  output crcfr_pkg::beat_t    q_data
);

  localparam int AW = crcfr_pkg::ADDR_W;
  localparam int PW = crcfr_pkg::POS_W;
  localparam logic [PW-1:0] BEAT_P = PW'(crcfr_pkg::BEAT_BYTES);

  crcfr_pkg::front_state_t state, state_next;

  logic [7:0]    mem [crcfr_pkg::FRAME_LEN];
  logic [7:0]    rd_data;
  logic [PW-1:0] fill, fill_next;
  logic [AW-1:0] head, head_next;
  logic [PW-1:0] issue_pos, issue_pos_next, issue_end, issue_end_next;
  logic          dv, dv_next;
  logic [PW-1:0] dpos, dpos_next;
  logic [7:0]    sync0, sync0_next, slot, slot_next, ftype, ftype_next, stop, stop_next;
  logic [15:0]   len, len_next, rxcrc, rxcrc_next, crc, crc_next;
  logic [PW-1:0] beat_start, beat_start_next;
  logic [4:0]    bi, bi_next;
  logic [63:0]   word, word_next;

  logic          issuing, bad, emit, wr_en;
  logic [PW-1:0] len9, rem, rem_rest, lane_pos;
  logic [3:0]    nvalid;
  logic          last;

  assign issuing  = (issue_pos != issue_end);
  assign len9     = len[PW-1:0];
  assign rem      = len9 - beat_start;
  assign rem_rest = rem - BEAT_P;
  assign lane_pos = dpos - crcfr_pkg::POS_DATA;
  assign last     = (rem <= BEAT_P);
  assign nvalid   = last ? rem[3:0] : 4'(crcfr_pkg::BEAT_BYTES);
  assign bad = (sync0 != crcfr_pkg::SYNC_START) || (stop != crcfr_pkg::SYNC_STOP) ||
               (len > 16'(MAX_DATA)) ||
               ((ftype == crcfr_pkg::TYPE_UIO) && (len != 16'(UIO_LEN)));
  assign emit = ((ftype <= crcfr_pkg::TYPE_METRIC) && cfg.sig_en) ||
                ((ftype == crcfr_pkg::TYPE_UIO) && cfg.uio_en);
  assign wr_en = rx.valid && rx.ready;

  // Window memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[head + fill[AW-1:0]] <= rx.rx_byte;
    rd_data <= mem[head + issue_pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crcfr_pkg::S_IDLE;
      fill  <= '0;
      head  <= '0;
      dv    <= 1'b0;
      issue_pos <= '0;
      issue_end <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      head  <= head_next;
      dv    <= dv_next;
      issue_pos <= issue_pos_next;
      issue_end <= issue_end_next;
    end
  end

  always_ff @(posedge clk) begin
    dpos  <= dpos_next;
    sync0 <= sync0_next;
    slot  <= slot_next;
    ftype <= ftype_next;
    stop  <= stop_next;
    len   <= len_next;
    rxcrc <= rxcrc_next;
    crc   <= crc_next;
    beat_start <= beat_start_next;
    bi    <= bi_next;
    word  <= word_next;
  end

  // Beat record for the queue
  always_comb begin
    q_data.slot_number  = slot;
    q_data.frame_type   = ftype[1:0];
    q_data.frame_length = len[7:0];
    q_data.data_word    = word;
    q_data.bytes_valid  = nvalid;
    q_data.beat_index   = bi;
    q_data.last_beat    = last;
  end

  // Sequence the window check and beat assembly
  always_comb begin
    state_next = state;
    fill_next = fill;
    head_next = head;
    issue_pos_next = issue_pos;
    issue_end_next = issue_end;
    dv_next = 1'b0;
    dpos_next = dpos;
    sync0_next = sync0;
    slot_next = slot;
    ftype_next = ftype;
    stop_next = stop;
    len_next = len;
    rxcrc_next = rxcrc;
    crc_next = crc;
    beat_start_next = beat_start;
    bi_next = bi;
    word_next = word;
    rx.ready = 1'b0;
    q_push = 1'b0;

    // advance the read pointer in the reading states
    if ((state == crcfr_pkg::S_HDR0 || state == crcfr_pkg::S_HDR1 ||
         state == crcfr_pkg::S_CRC || state == crcfr_pkg::S_DATA) && issuing) begin
      dv_next = 1'b1;
      dpos_next = issue_pos;
      issue_pos_next = issue_pos + 1'b1;
    end

    case (state)
      crcfr_pkg::S_IDLE: begin
        rx.ready = 1'b1;
        if (rx.valid) begin
          fill_next = fill + 1'b1;
          if (fill == crcfr_pkg::POS_STOP) begin
            state_next = crcfr_pkg::S_HDR0;
            issue_pos_next = crcfr_pkg::POS_SYNC;
            issue_end_next = crcfr_pkg::POS_DATA;
          end
        end
      end
      crcfr_pkg::S_HDR0, crcfr_pkg::S_HDR1: begin
        if (dv) begin
          case (dpos)
            crcfr_pkg::POS_SYNC:   sync0_next = rd_data;
            crcfr_pkg::POS_SLOT:   slot_next = rd_data;
            crcfr_pkg::POS_TYPE:   ftype_next = rd_data;
            crcfr_pkg::POS_LEN_LO: len_next[7:0] = rd_data;
            crcfr_pkg::POS_LEN_HI: len_next[15:8] = rd_data;
            crcfr_pkg::POS_CRC_LO: rxcrc_next[7:0] = rd_data;
            crcfr_pkg::POS_CRC_HI: rxcrc_next[15:8] = rd_data;
            crcfr_pkg::POS_STOP:   stop_next = rd_data;
            default: ;
          endcase
        end
        if (!issuing && !dv) begin
          if (state == crcfr_pkg::S_HDR0) begin
            state_next = crcfr_pkg::S_HDR1;
            issue_pos_next = crcfr_pkg::POS_CRC_LO;
            issue_end_next = crcfr_pkg::POS_END;
          end else begin
            state_next = crcfr_pkg::S_EVAL;
          end
        end
      end
      crcfr_pkg::S_EVAL: begin
        if (bad) begin
          head_next = head + 1'b1;
          fill_next = crcfr_pkg::POS_STOP;
          state_next = crcfr_pkg::S_IDLE;
        end else begin
          crc_next = crcfr_pkg::CRC_INIT;
          issue_pos_next = crcfr_pkg::POS_LEN_LO;
          issue_end_next = crcfr_pkg::POS_DATA + len9;
          state_next = crcfr_pkg::S_CRC;
        end
      end
      crcfr_pkg::S_CRC: begin
        if (dv) crc_next = crcfr_pkg::crc_byte(crc, rd_data);
        if (!issuing && !dv) state_next = crcfr_pkg::S_DEC;
      end
      crcfr_pkg::S_DEC: begin
        if (crc != rxcrc) begin
          head_next = head + 1'b1;
          fill_next = crcfr_pkg::POS_STOP;
          state_next = crcfr_pkg::S_IDLE;
        end else if (!emit) begin
          fill_next = '0;
          state_next = crcfr_pkg::S_IDLE;
        end else begin
          beat_start_next = '0;
          bi_next = '0;
          word_next = '0;
          issue_pos_next = crcfr_pkg::POS_DATA;
          issue_end_next = crcfr_pkg::POS_DATA + ((len9 > BEAT_P) ? BEAT_P : len9);
          state_next = crcfr_pkg::S_DATA;
        end
      end
      crcfr_pkg::S_DATA: begin
        if (dv) word_next[8*lane_pos[2:0] +: 8] = rd_data;
        if (!issuing && !dv) state_next = crcfr_pkg::S_PUSH;
      end
      crcfr_pkg::S_PUSH: begin
        if (!q_stat.full) begin
          q_push = 1'b1;
          if (last) begin
            fill_next = '0;
            state_next = crcfr_pkg::S_IDLE;
          end else begin
            beat_start_next = beat_start + BEAT_P;
            bi_next = bi + 1'b1;
            word_next = '0;
            issue_pos_next = crcfr_pkg::POS_DATA + beat_start + BEAT_P;
            issue_end_next = crcfr_pkg::POS_DATA + beat_start + BEAT_P +
                             ((rem_rest > BEAT_P) ? BEAT_P : rem_rest);
            state_next = crcfr_pkg::S_DATA;
          end
        end
      end
      default: state_next = crcfr_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/crcfr_queue.sv
`timescale 1ns / 1ps
module crcfr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  crcfr_pkg::beat_t       push_data,
  input  logic                   pop,
  output crcfr_pkg::beat_t       pop_data,
  output crcfr_pkg::queue_stat_t stat
);

  localparam int PW = crcfr_pkg::Q_PTR_W;

  crcfr_pkg::beat_t slots [crcfr_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign stat.full  = (count == (PW+1)'(crcfr_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];

  // Store beat records in arrival order
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

FILE: src/crcfr_back.sv
`timescale 1ns / 1ps
module crcfr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  crcfr_pkg::queue_stat_t q_stat,
  input  crcfr_pkg::beat_t       q_data,
  output logic                   q_pop,
  crcfr_beat_if.source           tx
);

  crcfr_pkg::beat_t hold;
  logic             full;

  // Load a new beat when the output register is free or being drained
  assign q_pop = !q_stat.empty && (!full || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (q_pop) begin
      full <= 1'b1;
    end else if (tx.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) hold <= q_data;
  end

  assign tx.valid        = full;
  assign tx.slot_number  = hold.slot_number;
  assign tx.frame_type   = hold.frame_type;
  assign tx.frame_length = hold.frame_length;
  assign tx.data_word    = hold.data_word;
  assign tx.bytes_valid  = hold.bytes_valid;
  assign tx.beat_index   = hold.beat_index;
  assign tx.last_beat    = hold.last_beat;

endmodule

FILE: src/crc_framed_packet_receiver.sv
`timescale 1ns / 1ps
// Bytes are taken one a cycle until the 256-byte window fills; the window check then
// reads the window memory one byte a cycle, first the header and trailer fields, then the
// length and data bytes for the CRC; the byte input is then ready again on a failed frame.
// An emitted frame is then read out again in beats of 8 bytes, each pushed to the queue.
// Pushed beats pass through a 4-entry queue into the registered output, held until tx.ready.
// Synchronous active-high reset clears the window fill, head, queue and output valid.
`include "assert_macros.svh"
module crc_framed_packet_receiver #(
  parameter int MAX_DATA = crcfr_pkg::MAX_DATA_DEF,
  parameter int UIO_LEN  = crcfr_pkg::UIO_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  crcfr_byte_if.sink  rx,
  crcfr_beat_if.source tx,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  crcfr_pkg::cfg_t        cfg;
  crcfr_pkg::queue_stat_t q_stat;
  crcfr_pkg::beat_t       push_data, pop_data;
  logic                   q_push, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig_en <= 1'b1;
      cfg.uio_en <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        crcfr_pkg::CFG_SIGNAL_EN: cfg.sig_en <= cfg_data;
        crcfr_pkg::CFG_UIO_EN:    cfg.uio_en <= cfg_data;
        default: ;
      endcase
    end
  end

  crcfr_front #(.MAX_DATA(MAX_DATA), .UIO_LEN(UIO_LEN)) u_front (
    .clk(clk), .rst(rst), .rx(rx), .cfg(cfg), .q_stat(q_stat),
    .q_push(q_push), .q_data(push_data)
  );

  crcfr_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(push_data),
    .pop(q_pop), .pop_data(pop_data), .stat(q_stat)
  );

  crcfr_back u_back (
    .clk(clk), .rst(rst), .q_stat(q_stat), .q_data(pop_data),
    .q_pop(q_pop), .tx(tx)
  );

  `CHK_IMPL(a_no_overflow, q_push, !q_stat.full)
  `CHK_IMPL(a_no_underflow, q_pop, !q_stat.empty)
  `CHK_NEXT(a_cfg_sig, cfg_we && (cfg_index == crcfr_pkg::CFG_SIGNAL_EN), cfg.sig_en == $past(cfg_data))

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import crcfr_pkg::*;

  localparam int STOP_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 600;

  typedef enum logic [2:0] {
    DEF_NONE, DEF_HEAD, DEF_TAIL, DEF_CRC
  } defect_t;

  typedef enum logic {
    ROW_FRAME, ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  slot;
    logic [7:0]  ftype;
    logic [15:0] len;
    defect_t     defect;
    int          junk;
    bit          typed;
    bit          sig;
    bit          uio;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic cfg_data;

  crcfr_byte_if rx ();
  crcfr_beat_if tx ();

  crc_framed_packet_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .tx        (tx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receive window mirror and output enables
  logic [7:0] win_mem [FRAME_LEN];
  int         win_fill;
  int         win_head;
  bit         sig_on;
  bit         uio_on;

  beat_t      pending_beats [$];
  int         errors;
  int         cycles;
  int         send_idle;
  int         recv_idle;
  int         phase_beats;
  logic [7:0] frame_buf [FRAME_LEN];

  function automatic logic [15:0] crc16_ccitt(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] win_byte(input int pos);
    return win_mem[(win_head + pos) % FRAME_LEN];
  endfunction

  // Take one byte into the window; return the beats that it releases
  function automatic void window_take(input logic [7:0] b, ref beat_t beats[$]);
    int          len;
    int          ftype;
    int          nbeats;
    int          nvalid;
    logic [15:0] crc;
    bit          ok;
    beat_t       bt;
    win_mem[(win_head + win_fill) % FRAME_LEN] = b;
    win_fill++;
    if (win_fill < FRAME_LEN) return;
    len = {win_byte(4), win_byte(3)};
    ftype = win_byte(2);
    ok = win_byte(0) == 8'h55 && win_byte(255) == 8'hAA && len <= 248 &&
         !(ftype == 2 && len != 8);
    if (ok) begin
      crc = 16'hEF4A;
      for (int k = 0; k < len + 2; k++) crc = crc16_ccitt(crc, win_byte(3 + k));
      ok = crc == {win_byte(254), win_byte(253)};
    end
    if (!ok) begin
      win_head = (win_head + 1) % FRAME_LEN;
      win_fill = FRAME_LEN - 1;
      return;
    end
    win_fill = 0;
    if (!((ftype <= 1 && sig_on) || (ftype == 2 && uio_on))) return;
    nbeats = (len + 7) / 8;
    if (nbeats == 0) nbeats = 1;
    for (int i = 0; i < nbeats; i++) begin
      nvalid = len - 8 * i;
      if (nvalid > 8) nvalid = 8;
      bt.slot_number = win_byte(1);
      bt.frame_type = ftype[1:0];
      bt.frame_length = len[7:0];
      bt.data_word = '0;
      for (int k = 0; k < nvalid; k++) bt.data_word[8*k +: 8] = win_byte(5 + 8 * i + k);
      bt.bytes_valid = nvalid[3:0];
      bt.beat_index = i[4:0];
      bt.last_beat = (i + 1 == nbeats);
      beats.push_back(bt);
    end
  endfunction

  // Lay out one frame, with CRC, into frame_buf
  function automatic void build_frame(input logic [7:0] slot, input logic [7:0] ftype,
                                      input logic [15:0] len, input defect_t defect);
    logic [15:0] crc;
    for (int i = 0; i < FRAME_LEN; i++) frame_buf[i] = $urandom_range(255);
    frame_buf[0] = 8'h55;
    frame_buf[1] = slot;
    frame_buf[2] = ftype;
    frame_buf[3] = len[7:0];
    frame_buf[4] = len[15:8];
    frame_buf[255] = 8'hAA;
    if (len <= 248) begin
      crc = 16'hEF4A;
      for (int k = 0; k < len + 2; k++) crc = crc16_ccitt(crc, frame_buf[3 + k]);
      frame_buf[253] = crc[7:0];
      frame_buf[254] = crc[15:8];
    end
    case (defect)
      DEF_HEAD: frame_buf[0] ^= $urandom_range(255, 1);
      DEF_TAIL: frame_buf[255] ^= $urandom_range(255, 1);
      DEF_CRC: begin
        crc = $urandom_range(16'hFFFF, 1);
        frame_buf[253] ^= crc[7:0];
        frame_buf[254] ^= crc[15:8];
      end
      default: ;
    endcase
  endfunction

  // Hand one byte over; valid stays high for the next one
  task automatic send_byte(input logic [7:0] b, input bit last_of_row, input bit typed);
    beat_t got [$];
    beat_t bt;
    while ($urandom_range(99) < send_idle) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    window_take(b, got);
    if (last_of_row && typed) begin
      got.delete();
      // Zero-length frame that is emitted: one empty closing beat
      if (frame_buf[0] == 8'h55 && frame_buf[3] == 8'h00 && frame_buf[4] == 8'h00 &&
          frame_buf[2] <= 8'd1 && sig_on) begin
        bt = '0;
        bt.slot_number = frame_buf[1];
        bt.frame_type = frame_buf[2][1:0];
        bt.last_beat = 1'b1;
        got.push_back(bt);
      end
    end
    phase_beats += got.size();
    foreach (got[i]) pending_beats.push_back(got[i]);
    @(negedge clk);
  endtask

  task automatic send_frame(input int junk, input bit typed);
    for (int i = 0; i < junk; i++) send_byte($urandom_range(255), 1'b0, 1'b0);
    for (int i = 0; i < FRAME_LEN; i++) send_byte(frame_buf[i], i == FRAME_LEN - 1, typed);
  endtask

  // Hold off until every expected beat is out and the checker has gone quiet
  task automatic wait_idle();
    rx.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_enables(input bit sig, input bit uio);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SIGNAL_EN;
    cfg_data <= sig;
    @(negedge clk);
    cfg_index <= CFG_UIO_EN;
    cfg_data <= uio;
    @(negedge clk);
    cfg_we <= 1'b0;
    sig_on = sig;
    uio_on = uio;
  endtask

  // Random frame traffic until enough beats have come out
  task automatic random_traffic(input int beat_goal);
    int          pick;
    logic [7:0]  ftype;
    logic [15:0] len;
    defect_t     defect;
    int          junk;
    phase_beats = 0;
    while (phase_beats < beat_goal) begin
      pick = $urandom_range(99);
      ftype = (pick < 8) ? $urandom_range(255, 3) : $urandom_range(2);
      pick = $urandom_range(99);
      if (ftype == TYPE_UIO && pick < 85) len = 8;
      else if (pick < 70) len = $urandom_range(24);
      else if (pick < 88) len = $urandom_range(248, 25);
      else if (pick < 94) len = 248;
      else len = $urandom_range(16'hFFFF, 249);
      pick = $urandom_range(99);
      defect = (pick < 4) ? DEF_HEAD : (pick < 7) ? DEF_TAIL : (pick < 10) ? DEF_CRC : DEF_NONE;
      junk = ($urandom_range(99) < 10) ? $urandom_range(6, 1) : 0;
      build_frame($urandom_range(255), ftype, len, defect);
      send_frame(junk, 1'b0);
    end
  endtask

  // Compare each transfer against the oldest expected beat
  always @(posedge clk) begin
    beat_t want;
    if (!rst && tx.valid && tx.ready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: slot %0h idx %0d", tx.slot_number,
                                   tx.beat_index);
      end else begin
        want = pending_beats.pop_front();
        if (tx.slot_number !== want.slot_number || tx.frame_type !== want.frame_type ||
            tx.frame_length !== want.frame_length || tx.data_word !== want.data_word ||
            tx.bytes_valid !== want.bytes_valid || tx.beat_index !== want.beat_index ||
            tx.last_beat !== want.last_beat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0h/%0d/%0d/%h/%0d/%0d/%0d got %0h/%0d/%0d/%h/%0d/%0d/%0d",
                     want.slot_number, want.frame_type, want.frame_length, want.data_word,
                     want.bytes_valid, want.beat_index, want.last_beat,
                     tx.slot_number, tx.frame_type, tx.frame_length, tx.data_word,
                     tx.bytes_valid, tx.beat_index, tx.last_beat);
        end
      end
    end
  end

  // Throttle the output side
  always @(negedge clk) begin
    tx.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= STOP_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    row_t rows [$];
    rows = '{
      '{ROW_FRAME, 8'h00, 8'd0, 16'd0,      DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'hFF, 8'd1, 16'd248,    DEF_NONE, 0, 0, 0, 0},
      '{ROW_FRAME, 8'h5A, 8'd2, 16'd8,      DEF_NONE, 0, 0, 0, 0},
      '{ROW_FRAME, 8'h11, 8'd2, 16'd7,      DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h22, 8'd0, 16'd249,    DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h33, 8'd1, 16'h0100,   DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h44, 8'd0, 16'd4,      DEF_HEAD, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h45, 8'd0, 16'd4,      DEF_TAIL, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h46, 8'd1, 16'd12,     DEF_CRC,  0, 1, 0, 0},
      '{ROW_FRAME, 8'h47, 8'd3, 16'd5,      DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h48, 8'd255, 16'd0,    DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h49, 8'd1, 16'd9,      DEF_NONE, 2, 0, 0, 0},
      '{ROW_FRAME, 8'hA5, 8'd0, 16'd1,      DEF_NONE, 0, 0, 0, 0},
      '{ROW_CFG,   8'h00, 8'd0, 16'd0,      DEF_NONE, 0, 0, 0, 1},
      '{ROW_FRAME, 8'h50, 8'd0, 16'd3,      DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h51, 8'd2, 16'd8,      DEF_NONE, 0, 0, 0, 0},
      '{ROW_CFG,   8'h00, 8'd0, 16'd0,      DEF_NONE, 0, 0, 1, 0},
      '{ROW_FRAME, 8'h52, 8'd2, 16'd8,      DEF_NONE, 0, 1, 0, 0},
      '{ROW_FRAME, 8'h53, 8'd1, 16'd17,     DEF_NONE, 0, 0, 0, 0},
      '{ROW_CFG,   8'h00, 8'd0, 16'd0,      DEF_NONE, 0, 0, 1, 1}
    };
    errors = 0;
    cycles = 0;
    win_fill = 0;
    win_head = 0;
    sig_on = 1'b1;
    uio_on = 1'b1;
    foreach (win_mem[i]) win_mem[i] = '0;
    send_idle = 37;
    recv_idle = 64;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SIGNAL_EN;
    cfg_data = 1'b0;
    rx.valid = 1'b0;
    rx.rx_byte = '0;
    tx.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_enables(rows[i].sig, rows[i].uio);
      end else begin
        build_frame(rows[i].slot, rows[i].ftype, rows[i].len, rows[i].defect);
        send_frame(rows[i].junk, rows[i].typed);
      end
    end

    // Random traffic in three throttle settings
    random_traffic(24);
    wait_idle();
    case ($urandom_range(2))
      0: write_enables(1'b0, 1'b1);
      1: write_enables(1'b1, 1'b0);
      default: write_enables(1'b1, 1'b1);
    endcase
    send_idle = 64;
    recv_idle = 37;
    random_traffic(16);
    write_enables(1'b1, 1'b1);
    send_idle = 0;
    recv_idle = 0;
    random_traffic(24);

    // Drain and report
    rx.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: crc_framed_packet_receiver.f
+incdir+src
src/crcfr_pkg.sv
src/crcfr_if.sv
src/crcfr_front.sv
src/crcfr_queue.sv
src/crcfr_back.sv
src/crc_framed_packet_receiver.sv
bench/tb_top.sv
